// ===== sv/pure_pursuit_velocity_command_defines.svh =====
// Assertion macros for the pure pursuit block.
`ifndef PURE_PURSUIT_VELOCITY_COMMAND_DEFINES_SVH
`define PURE_PURSUIT_VELOCITY_COMMAND_DEFINES_SVH
`ifndef SYNTH
`define PPV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPV_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPV_ASSERT(label, clk, rst_n, prop, msg)
`define PPV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== sv/ppv_pkg.sv =====
`timescale 1ns / 1ps
package ppv_pkg;
    localparam logic [1:0] FUNC_NEW    = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_POSE   = 2'd2;

    localparam logic [1:0] ST_DRIVING = 2'd0;
    localparam logic [1:0] ST_ARRIVED = 2'd1;
    localparam logic [1:0] ST_NO_PATH = 2'd2;

    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_SPEED     = 2'd1;
    localparam logic [1:0] REG_TOL       = 2'd2;

    localparam int SQRT_BITS = 33;
    localparam int DIV_BITS  = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEAR_RD,
        S_NEAR_CMP,
        S_LAST_RD,
        S_LAST_CMP,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_GOAL_RD,
        S_GOAL_SUM,
        S_SQRT,
        S_DIV,
        S_NEG,
        S_OUT
    } state_t;
endpackage

// ===== sv/pure_pursuit_velocity_command.sv =====
`timescale 1ns / 1ps
// Pure pursuit velocity command.
// Input channel (valid/ready): func, pos_x, pos_y. func 0 starts a path with
// one waypoint, func 1 appends one unless the path is full, func 2 is a robot
// pose. Path beats give no result; func 3 is dropped.
// A pose beat gives one result beat on the output channel: vel_x, vel_y,
// status, target_index. The pose runs a nearest-point scan from the stored
// search start, a lookahead scan from the nearest point when the endpoint
// lies beyond the lookahead, a 33-step square root and a 64-step
// shift/subtract division per axis, all through one read port of the
// waypoint memory. On arrival the velocity is zero, with no root or division.
// Only one item is in flight: input ready stays low while a pose is worked
// and while its result beat waits in the output register, so a stalled
// receiver holds off the next item until that beat is taken.
// Reset empties the path, clears the search start and loads the register
// defaults (lookahead 1.0 m, speed 1.0 m/s, tolerance 0.1 m). The waypoint
// memory holds no reset value and needs no clearing pass.
// Configuration: APB, registers at byte addresses 0, 4, 8; pready is high.
module pure_pursuit_velocity_command #(
    parameter int MAX_WAYPOINTS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic [1:0]         status,
    output logic [7:0]         target_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
`include "pure_pursuit_velocity_command_defines.svh"

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_WAYPOINTS);

    // waypoint memory
    logic [63:0] mem [MAX_WAYPOINTS];
    logic [63:0] rd_data;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [63:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // configuration
    logic [30:0] look_reg, speed_reg, tol_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_reg  <= 31'd65536;
            speed_reg <= 31'd65536;
            tol_reg   <= 31'd6554;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                ppv_pkg::REG_LOOKAHEAD: look_reg  <= pwdata[30:0];
                ppv_pkg::REG_SPEED:     speed_reg <= pwdata[30:0];
                ppv_pkg::REG_TOL:       tol_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ppv_pkg::REG_LOOKAHEAD: prdata = {1'b0, look_reg};
            ppv_pkg::REG_SPEED:     prdata = {1'b0, speed_reg};
            ppv_pkg::REG_TOL:       prdata = {1'b0, tol_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // datapath registers
    ppv_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] near_reg, near_next;
    logic [AW-1:0] goal_reg, goal_next;
    logic signed [31:0] px_reg, py_reg;
    logic [65:0] best_reg, best_next;
    logic [63:0] sq_reg, sq_next;       // first square of the pair
    logic [65:0] sum_reg, sum_next;
    logic        half_reg, half_next;   // which square of the pair
    logic        ytol_reg, ytol_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [32:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic        axis_reg, axis_next;
    logic [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic        ov_reg, ov_next;
    logic [1:0]  st_reg, st_next;
    logic [7:0]  ti_reg, ti_next;

    // combinational helpers
    logic signed [32:0] ex, ey;
    logic [32:0] ax, ay, am;
    logic [63:0] prod;
    logic [65:0] dist_sum;
    logic [65:0] l2;
    logic [32:0] cand;
    logic [65:0] cand_sq;
    logic [33:0] rem_sh;
    logic signed [32:0] dsel;

    assign ex = 33'(signed'(rd_data[31:0])) - 33'(px_reg);
    assign ey = 33'(signed'(rd_data[63:32])) - 33'(py_reg);
    assign ax = ex[32] ? 33'(-ex) : 33'(ex);
    assign ay = ey[32] ? 33'(-ey) : 33'(ey);
    assign am = half_reg ? ay : ax;
    // squares of 32-bit magnitudes, one per cycle
    assign prod = am[31:0] * am[31:0];
    assign dist_sum = sum_reg;
    assign l2 = 66'(look_reg) * 66'(look_reg);
    assign cand = root_reg | (33'd1 << cnt_reg);
    assign cand_sq = 66'(cand) * 66'(cand);
    assign rem_sh = {rem_reg, num_reg[63]};
    assign dsel = axis_reg ? dy_reg : dx_reg;

    assign in_ready = (state_reg == ppv_pkg::S_IDLE) && !ov_reg;

    logic in_fire, out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppv_pkg::S_IDLE;
            count_reg <= '0;
            start_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
        idx_reg  <= idx_next;
        near_reg <= near_next;
        goal_reg <= goal_next;
        best_reg <= best_next;
        sq_reg   <= sq_next;
        sum_reg  <= sum_next;
        half_reg <= half_next;
        ytol_reg <= ytol_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        axis_reg <= axis_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        st_reg   <= st_next;
        ti_reg   <= ti_next;
    end

    // Each distance: cycle A registers the x square, cycle B adds the y square
    // into sum_reg and runs the compare on that sum as it is formed.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        start_next = start_reg;
        ov_next    = ov_reg;
        idx_next   = idx_reg;
        near_next  = near_reg;
        goal_next  = goal_reg;
        best_next  = best_reg;
        sq_next    = sq_reg;
        sum_next   = sum_reg;
        half_next  = half_reg;
        ytol_next  = ytol_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        axis_next  = axis_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        st_next    = st_reg;
        ti_next    = ti_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = {pos_y, pos_x};
        rd_addr    = idx_reg;

        if (out_fire)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ppv_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == ppv_pkg::FUNC_NEW || func == ppv_pkg::FUNC_APPEND)
                    begin
                        wr_addr = (func == ppv_pkg::FUNC_NEW) ? '0 : count_reg[AW-1:0];
                        if (func == ppv_pkg::FUNC_NEW)
                        begin
                            start_next = '0;
                            wr_en      = 1'b1;
                            count_next = CW'(1);
                        end
                        else if (count_reg < MAXC)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (func == ppv_pkg::FUNC_POSE)
                    begin
                        if (count_reg == '0)
                        begin
                            vx_next = '0;
                            vy_next = '0;
                            st_next = ppv_pkg::ST_NO_PATH;
                            ti_next = '0;
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            idx_next  = (CW'(start_reg) < count_reg) ? start_reg
                                        : AW'(count_reg - CW'(1));
                            near_next = idx_next;
                            half_next = 1'b0;
                            state_next = ppv_pkg::S_NEAR_RD;
                        end
                    end
                end
            end
            ppv_pkg::S_NEAR_RD:
            begin
                // read issued by rd_addr = idx_reg; data next cycle
                half_next  = 1'b0;
                state_next = ppv_pkg::S_NEAR_CMP;
            end
            ppv_pkg::S_NEAR_CMP:
            begin
                if (!half_reg)
                begin
                    sq_next   = prod;
                    half_next = 1'b1;
                end
                else
                begin
                    sum_next = 66'(sq_reg) + 66'(prod);
                    if (idx_reg == near_reg || sum_next < best_reg)
                    begin
                        best_next = sum_next;
                        near_next = idx_reg;
                    end
                    if (CW'(idx_reg) + CW'(1) < count_reg)
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ppv_pkg::S_NEAR_RD;
                    end
                    else
                    begin
                        start_next = near_next;
                        idx_next   = AW'(count_reg - CW'(1));
                        state_next = ppv_pkg::S_LAST_RD;
                    end
                end
            end
            ppv_pkg::S_LAST_RD:
            begin
                half_next  = 1'b0;
                state_next = ppv_pkg::S_LAST_CMP;
            end
            ppv_pkg::S_LAST_CMP:
            begin
                if (!half_reg)
                begin
                    sq_next   = prod;
                    half_next = 1'b1;
                    ytol_next = ay < 33'(tol_reg);
                end
                else
                begin
                    sum_next = 66'(sq_reg) + 66'(prod);
                    goal_next = idx_reg;
                    // arrival check on the endpoint, reported after goal search
                    st_next = (near_reg == idx_reg && ax < 33'(tol_reg) && ytol_reg)
                              ? ppv_pkg::ST_ARRIVED : ppv_pkg::ST_DRIVING;
                    if (sum_next > l2)
                    begin
                        idx_next   = near_reg;
                        state_next = ppv_pkg::S_LOOK_RD;
                    end
                    else
                    begin
                        state_next = ppv_pkg::S_GOAL_RD;
                    end
                end
            end
            ppv_pkg::S_LOOK_RD:
            begin
                half_next  = 1'b0;
                state_next = ppv_pkg::S_LOOK_CMP;
            end
            ppv_pkg::S_LOOK_CMP:
            begin
                if (!half_reg)
                begin
                    sq_next   = prod;
                    half_next = 1'b1;
                end
                else
                begin
                    sum_next = 66'(sq_reg) + 66'(prod);
                    if (sum_next > l2)
                    begin
                        goal_next  = (idx_reg > near_reg) ? idx_reg - AW'(1) : near_reg;
                        state_next = ppv_pkg::S_GOAL_RD;
                    end
                    else
                    begin
                        // endpoint is beyond lookahead, so the scan stops first
                        idx_next   = idx_reg + AW'(1);
                        state_next = ppv_pkg::S_LOOK_RD;
                    end
                end
            end
            ppv_pkg::S_GOAL_RD:
            begin
                idx_next   = goal_reg;
                rd_addr    = goal_reg;
                half_next  = 1'b0;
                ti_next    = 8'(goal_reg);
                if (st_reg == ppv_pkg::ST_ARRIVED)
                begin
                    vx_next    = '0;
                    vy_next    = '0;
                    ov_next    = 1'b1;
                    state_next = ppv_pkg::S_IDLE;
                end
                else
                begin
                    state_next = ppv_pkg::S_GOAL_SUM;
                end
            end
            ppv_pkg::S_GOAL_SUM:
            begin
                dx_next = ex;
                dy_next = ey;
                if (!half_reg)
                begin
                    sq_next   = prod;
                    half_next = 1'b1;
                end
                else
                begin
                    sum_next   = 66'(sq_reg) + 66'(prod);
                    root_next  = '0;
                    cnt_next   = 6'(ppv_pkg::SQRT_BITS - 1);
                    state_next = ppv_pkg::S_SQRT;
                end
            end
            ppv_pkg::S_SQRT:
            begin
                if (cand_sq <= dist_sum)
                begin
                    root_next = cand;
                end
                if (cnt_reg == '0)
                begin
                    axis_next = 1'b0;
                    state_next = ppv_pkg::S_DIV;
                    num_next  = 64'(speed_reg) * 64'(dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg));
                    rem_next  = '0;
                    cnt_next  = 6'(ppv_pkg::DIV_BITS - 1);
                    if (root_next == '0)
                    begin
                        vx_next    = '0;
                        vy_next    = '0;
                        ov_next    = 1'b1;
                        state_next = ppv_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ppv_pkg::S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                num_next = {num_reg[62:0], 1'b0};
                if (rem_sh >= 34'(root_reg))
                begin
                    rem_next = 33'(rem_sh - 34'(root_reg));
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[32:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = ppv_pkg::S_NEG;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ppv_pkg::S_NEG:
            begin
                if (!axis_reg)
                begin
                    vx_next   = dsel[32] ? 32'(-quo_reg) : quo_reg[31:0];
                    axis_next = 1'b1;
                    num_next  = 64'(speed_reg) * 64'(dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg));
                    rem_next  = '0;
                    cnt_next  = 6'(ppv_pkg::DIV_BITS - 1);
                    state_next = ppv_pkg::S_DIV;
                end
                else
                begin
                    vy_next    = dsel[32] ? 32'(-quo_reg) : quo_reg[31:0];
                    state_next = ppv_pkg::S_OUT;
                end
            end
            ppv_pkg::S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = ppv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppv_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign vel_x        = vx_reg;
    assign vel_y        = vy_reg;
    assign status       = st_reg;
    assign target_index = ti_reg;

    `PPV_ASSERT(a_count_max, clk, rst_n, count_reg <= MAXC, "waypoint count overflow")
    `PPV_ASSERT(a_start_in_path, clk, rst_n,
        (count_reg != '0) |-> (CW'(start_reg) < count_reg), "search start past path")
    `PPV_ASSERT(a_out_hold, clk, rst_n,
        (out_valid && !out_ready) |=> (out_valid && $stable(vel_x) && $stable(status)),
        "result dropped while stalled")
    `PPV_ASSERT(a_busy_no_ready, clk, rst_n,
        (state_reg != ppv_pkg::S_IDLE) |-> !in_ready, "input taken while busy")
endmodule
